// File: hdl/tom_pkg.sv
// Shared types, codes and defaults for the 2-opt move engine.
package tom_pkg;

  localparam int MAX_CITIES_DEF = 512;
  localparam int REPLICAS_DEF   = 32;

  localparam logic [2:0] OP_LOAD_COORD = 3'd0;
  localparam logic [2:0] OP_LOAD_TOUR  = 3'd1;
  localparam logic [2:0] OP_SET_LEN    = 3'd2;
  localparam logic [2:0] OP_MOVE       = 3'd3;
  localparam logic [2:0] OP_READ       = 3'd4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_ILLEGAL = 2'd1;
  localparam logic [1:0] ST_RANGE   = 2'd2;

  localparam logic [29:0] BEST_RESET       = 30'd1000000000;
  localparam logic [9:0]  NUM_CITIES_RESET = 10'd4;

  localparam int DIST_W = 17;
  localparam int SUM_W  = 18;

  typedef struct packed {
    logic [2:0]  op;
    logic [4:0]  replica;
    logic [8:0]  pos_a;
    logic [8:0]  pos_b;
    logic [8:0]  city;
    logic [15:0] coord_x;
    logic [15:0] coord_y;
    logic [25:0] length_value;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        accepted;
    logic [17:0] gain;
    logic [25:0] tour_length;
    logic [29:0] best_length;
    logic [4:0]  best_replica;
    logic [8:0]  read_city;
  } out_t;

endpackage

// File: hdl/tom_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tom_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: hdl/tom_dist.sv
// Rounded Euclidean distance unit: squares, then a bit-pair square root.
module tom_dist import tom_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [31:0]       p_xy,
  input  logic [31:0]       q_xy,
  output logic              done,
  output logic [DIST_W-1:0] dist_val
);

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_SQ   = 3'd1;
  localparam logic [2:0] PH_ADD  = 3'd2;
  localparam logic [2:0] PH_IT   = 3'd3;
  localparam logic [2:0] PH_FIN  = 3'd4;

  logic [2:0]        phase_r;
  logic              done_r;
  logic [15:0]       dx_r, dy_r;
  logic [31:0]       sqx_r, sqy_r;
  logic [33:0]       v_r, r_r, bit_r;
  logic [DIST_W-1:0] dist_r;
  logic [33:0]       rb;
  logic              ge;

  assign rb = r_r + bit_r;
  assign ge = (v_r >= rb);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (phase_r)
        PH_IDLE: if (start) phase_r <= PH_SQ;
        PH_SQ:   phase_r <= PH_ADD;
        PH_ADD:  phase_r <= PH_IT;
        PH_IT:   if (bit_r[0]) phase_r <= PH_FIN;
        PH_FIN: begin
          done_r  <= 1'b1;
          phase_r <= PH_IDLE;
        end
        default: phase_r <= PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (phase_r)
      PH_IDLE: begin
        dx_r <= (p_xy[15:0] > q_xy[15:0]) ? p_xy[15:0] - q_xy[15:0] : q_xy[15:0] - p_xy[15:0];
        dy_r <= (p_xy[31:16] > q_xy[31:16]) ? p_xy[31:16] - q_xy[31:16]
                                            : q_xy[31:16] - p_xy[31:16];
      end
      PH_SQ: begin
        sqx_r <= 32'(dx_r) * 32'(dx_r);
        sqy_r <= 32'(dy_r) * 32'(dy_r);
      end
      PH_ADD: begin
        v_r   <= {2'b00, sqx_r} + {2'b00, sqy_r};
        r_r   <= '0;
        bit_r <= 34'd1 << 32;
      end
      PH_IT: begin
        if (ge) begin
          v_r <= v_r - rb;
          r_r <= (r_r >> 1) + bit_r;
        end else begin
          r_r <= r_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end
      PH_FIN: begin
        // round half up: bump when the remainder exceeds the root
        dist_r <= r_r[DIST_W-1:0] + DIST_W'(v_r > r_r);
      end
      default: begin
      end
    endcase
  end

  assign done     = done_r;
  assign dist_val = dist_r;

endmodule

// File: hdl/two_opt_move_engine.sv
// Top level of the 2-opt move engine: control sequencer and state memories.
//
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_stall   | in_data (in_t)
//  out_    | output    | out_valid/out_stall | out_data (out_t)
//  cfg_    | input     | cfg_we              | cfg_wdata (num_cities)
//
// Loads, sets and reads pass through the check and length states; a move
// reads its tour and coordinates, computes four distances (a 17-step root
// each) and, when accepted, rebuilds the tour via the tour and buffer RAMs.
// Reset clears the length valid bits and best replica, sets best length to
// 1000000000 and num_cities to 4.
// Input is stalled while a transaction is in work; output is registered.
module two_opt_move_engine import tom_pkg::*; #(
  parameter int MAX_CITIES = MAX_CITIES_DEF,
  parameter int REPLICAS   = REPLICAS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_t        in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output out_t       out_data,
  input  logic       cfg_we,
  input  logic [9:0] cfg_wdata
);

  localparam int CW     = $clog2(MAX_CITIES);
  localparam int NW     = CW + 1;
  localparam int RW     = (REPLICAS > 1) ? $clog2(REPLICAS) : 1;
  localparam int TW     = RW + CW;
  localparam int TDEPTH = 1 << TW;
  localparam logic [12:0] MAXC   = 13'(MAX_CITIES);
  localparam logic [6:0]  REPLIM = 7'(REPLICAS);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHK   = 4'd1;
  localparam logic [3:0] S_LEN   = 4'd2;
  localparam logic [3:0] S_TRD   = 4'd3;
  localparam logic [3:0] S_CRD   = 4'd4;
  localparam logic [3:0] S_DGO   = 4'd5;
  localparam logic [3:0] S_DWAIT = 4'd6;
  localparam logic [3:0] S_DEC   = 4'd7;
  localparam logic [3:0] S_RB1   = 4'd8;
  localparam logic [3:0] S_RB2   = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;

  logic [3:0]         state_r;
  in_t                item_r;
  logic [9:0]         num_cities_r;
  logic [CW-1:0]      a_r, b_r, src_r;
  logic [RW-1:0]      rep_r;
  logic [NW-1:0]      cnt_r;
  logic [1:0]         seg_r;
  logic [8:0]         s_r [4];
  logic [31:0]        crd_r [4];
  logic [25:0]        len_r;
  logic               len_pend_r;
  logic [SUM_W-1:0]   old_sum_r, new_sum_r, gain_r;
  logic               acc_r, rep_ok_r, rd_ok_r;
  logic [1:0]         status_r;
  logic [8:0]         rd_r;
  logic [REPLICAS-1:0] lvalid_r;
  logic [29:0]        best_len_r;
  logic [4:0]         best_idx_r;
  out_t               out_r;
  logic               out_valid_r;

  // item checks
  logic [12:0]   nc13, n13, pa13, pb13, lo13, hi13, city13;
  logic [NW-1:0] nn;
  logic          rep_ok, pa_ok, pb_ok, city_ok, illegal;
  logic [6:0]    rep7;
  logic [RW-1:0] rep_i;
  logic [CW-1:0] pa_i, city_i;

  assign nc13 = {3'b000, num_cities_r};
  assign n13  = (nc13 < 13'd4) ? 13'd4 : ((nc13 > MAXC) ? MAXC : nc13);
  assign nn   = n13[NW-1:0];
  assign pa13 = {4'b0000, item_r.pos_a};
  assign pb13 = {4'b0000, item_r.pos_b};
  assign city13 = {4'b0000, item_r.city};
  assign lo13 = (pa13 < pb13) ? pa13 : pb13;
  assign hi13 = (pa13 < pb13) ? pb13 : pa13;
  assign rep7 = {2'b00, item_r.replica};
  assign rep_ok  = rep7 < REPLIM;
  assign pa_ok   = pa13 < n13;
  assign pb_ok   = pb13 < n13;
  assign city_ok = city13 < MAXC;
  assign illegal = (lo13 == hi13) || (hi13 == lo13 + 13'd1) || (hi13 == n13 - 13'd1);
  assign rep_i  = rep7[RW-1:0];
  assign pa_i   = pa13[CW-1:0];
  assign city_i = city13[CW-1:0];

  // memories
  logic          t_we;
  logic [TW-1:0] t_waddr, t_raddr;
  logic [8:0]    t_wdata, t_rdata;
  logic          c_we;
  logic [CW-1:0] c_raddr;
  logic [31:0]   c_rdata;
  logic          b_we;
  logic [CW-1:0] b_addr_w, b_raddr;
  logic [8:0]    b_rdata;
  logic          l_we;
  logic [25:0]   l_wdata, l_rdata, lv_q;

  logic [NW-1:0] cm1;
  logic [CW-1:0] trd_pos;
  logic [12:0]   s13;
  logic [25:0]   newlen;
  logic [SUM_W-1:0] gain_c;
  logic          dstart, ddone;
  logic [DIST_W-1:0] dval;
  logic [31:0]   dp, dq;
  logic          out_load;

  assign cm1 = cnt_r - NW'(1);

  always_comb begin
    case (cnt_r[1:0])
      2'd0:    trd_pos = a_r;
      2'd1:    trd_pos = a_r + CW'(1);
      2'd2:    trd_pos = b_r;
      default: trd_pos = b_r + CW'(1);
    endcase
  end

  assign s13     = {4'b0000, s_r[cnt_r[1:0]]};
  assign c_raddr = s13[CW-1:0];

  always_comb begin
    case (state_r)
      S_TRD:   t_raddr = {rep_r, trd_pos};
      S_RB1:   t_raddr = {rep_r, src_r};
      default: t_raddr = {rep_i, pa_i};
    endcase
  end

  always_comb begin
    t_we    = 1'b0;
    t_waddr = {rep_i, pa_i};
    t_wdata = item_r.city;
    if (state_r == S_CHK) begin
      t_we = (item_r.op == OP_LOAD_TOUR) && rep_ok && pa_ok && city_ok;
    end else if (state_r == S_RB2) begin
      t_we    = (cnt_r != '0);
      t_waddr = {rep_r, cm1[CW-1:0]};
      t_wdata = b_rdata;
    end
  end

  assign c_we     = (state_r == S_CHK) && (item_r.op == OP_LOAD_COORD) && city_ok;
  assign b_we     = (state_r == S_RB1) && (cnt_r != '0);
  assign b_addr_w = cm1[CW-1:0];
  assign b_raddr  = cnt_r[CW-1:0];

  assign gain_c = old_sum_r - new_sum_r;
  assign newlen = (len_r > {8'd0, gain_c}) ? len_r - {8'd0, gain_c} : 26'd0;
  assign l_we   = ((state_r == S_CHK) && (item_r.op == OP_SET_LEN) && rep_ok)
               || ((state_r == S_DEC) && (old_sum_r > new_sum_r));
  assign l_wdata = (state_r == S_DEC) ? newlen : item_r.length_value;
  assign lv_q    = lvalid_r[rep_i] ? l_rdata : 26'd0;

  tom_ram #(.WIDTH(9), .DEPTH(TDEPTH)) u_tours (
    .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
    .raddr(t_raddr), .rdata(t_rdata)
  );

  tom_ram #(.WIDTH(32), .DEPTH(MAX_CITIES)) u_coords (
    .clk(clk), .we(c_we), .waddr(city_i),
    .wdata({item_r.coord_y, item_r.coord_x}),
    .raddr(c_raddr), .rdata(c_rdata)
  );

  tom_ram #(.WIDTH(9), .DEPTH(MAX_CITIES)) u_rebuild (
    .clk(clk), .we(b_we), .waddr(b_addr_w), .wdata(t_rdata),
    .raddr(b_raddr), .rdata(b_rdata)
  );

  tom_ram #(.WIDTH(26), .DEPTH(REPLICAS)) u_lengths (
    .clk(clk), .we(l_we), .waddr(rep_i), .wdata(l_wdata),
    .raddr(rep_i), .rdata(l_rdata)
  );

  // distance pairs: old edges first, then new edges
  always_comb begin
    case (cnt_r[1:0])
      2'd0:    begin dp = crd_r[0]; dq = crd_r[1]; end
      2'd1:    begin dp = crd_r[2]; dq = crd_r[3]; end
      2'd2:    begin dp = crd_r[0]; dq = crd_r[2]; end
      default: begin dp = crd_r[1]; dq = crd_r[3]; end
    endcase
  end

  assign dstart = (state_r == S_DGO);

  tom_dist u_dist (
    .clk(clk), .rst_n(rst_n), .start(dstart), .p_xy(dp), .q_xy(dq),
    .done(ddone), .dist_val(dval)
  );

  assign out_load = (state_r == S_OUT) && (!out_valid_r || !out_stall);

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      num_cities_r <= NUM_CITIES_RESET;
      lvalid_r     <= '0;
      best_len_r   <= BEST_RESET;
      best_idx_r   <= '0;
      out_valid_r  <= 1'b0;
      len_pend_r   <= 1'b0;
    end else begin
      if (cfg_we) num_cities_r <= cfg_wdata;
      len_pend_r  <= 1'b0;
      out_valid_r <= out_load | (out_valid_r & out_stall);
      if (l_we) lvalid_r[rep_i] <= 1'b1;
      case (state_r)
        S_IDLE: if (in_valid) state_r <= S_CHK;
        S_CHK: begin
          len_pend_r <= !((item_r.op == OP_SET_LEN) && rep_ok);
          if ((item_r.op == OP_MOVE) && rep_ok && pa_ok && pb_ok && !illegal) begin
            state_r <= S_TRD;
          end else begin
            state_r <= S_LEN;
          end
        end
        S_LEN: state_r <= S_OUT;
        S_TRD: if (cnt_r == NW'(4)) state_r <= S_CRD;
        S_CRD: if (cnt_r == NW'(4)) state_r <= S_DGO;
        S_DGO: state_r <= S_DWAIT;
        S_DWAIT: if (ddone) state_r <= (cnt_r == NW'(3)) ? S_DEC : S_DGO;
        S_DEC: begin
          if (old_sum_r > new_sum_r) begin
            state_r <= S_RB1;
            if ({4'd0, newlen} < best_len_r) begin
              best_len_r <= {4'd0, newlen};
              best_idx_r <= item_r.replica;
            end
          end else begin
            state_r <= S_OUT;
          end
        end
        S_RB1: if (cnt_r == nn) state_r <= S_RB2;
        S_RB2: if (cnt_r == nn) state_r <= S_OUT;
        S_OUT: if (out_load) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (len_pend_r) len_r <= lv_q;
    if (out_load) begin
      out_r.status       <= status_r;
      out_r.accepted     <= acc_r;
      out_r.gain         <= gain_r;
      out_r.tour_length  <= rep_ok_r ? len_r : 26'd0;
      out_r.best_length  <= best_len_r;
      out_r.best_replica <= best_idx_r;
      out_r.read_city    <= rd_r;
    end
    case (state_r)
      S_IDLE: if (in_valid) item_r <= in_data;
      S_CHK: begin
        rep_r     <= rep_i;
        a_r       <= lo13[CW-1:0];
        b_r       <= hi13[CW-1:0];
        rep_ok_r  <= rep_ok;
        acc_r     <= 1'b0;
        gain_r    <= '0;
        rd_r      <= '0;
        old_sum_r <= '0;
        new_sum_r <= '0;
        cnt_r     <= '0;
        rd_ok_r   <= (item_r.op == OP_READ) && rep_ok && pa_ok;
        if ((item_r.op == OP_SET_LEN) && rep_ok) len_r <= item_r.length_value;
        case (item_r.op)
          OP_LOAD_COORD: status_r <= city_ok ? ST_OK : ST_RANGE;
          OP_LOAD_TOUR:  status_r <= (rep_ok && pa_ok && city_ok) ? ST_OK : ST_RANGE;
          OP_SET_LEN:    status_r <= rep_ok ? ST_OK : ST_RANGE;
          OP_MOVE: begin
            if (!rep_ok || !pa_ok || !pb_ok) status_r <= ST_RANGE;
            else if (illegal)                status_r <= ST_ILLEGAL;
            else                             status_r <= ST_OK;
          end
          OP_READ:  status_r <= (rep_ok && pa_ok) ? ST_OK : ST_RANGE;
          default:  status_r <= ST_RANGE;
        endcase
      end
      S_LEN: if (rd_ok_r) rd_r <= t_rdata;
      S_TRD: begin
        if (cnt_r != '0) s_r[cm1[1:0]] <= t_rdata;
        cnt_r <= (cnt_r == NW'(4)) ? '0 : cnt_r + NW'(1);
      end
      S_CRD: begin
        if (cnt_r != '0) crd_r[cm1[1:0]] <= c_rdata;
        cnt_r <= (cnt_r == NW'(4)) ? '0 : cnt_r + NW'(1);
      end
      S_DWAIT: begin
        if (ddone) begin
          if (cnt_r < NW'(2)) old_sum_r <= old_sum_r + SUM_W'(dval);
          else                new_sum_r <= new_sum_r + SUM_W'(dval);
          if (cnt_r != NW'(3)) cnt_r <= cnt_r + NW'(1);
        end
      end
      S_DEC: begin
        cnt_r <= '0;
        seg_r <= 2'd0;
        src_r <= a_r;
        if (old_sum_r > new_sum_r) begin
          acc_r  <= 1'b1;
          gain_r <= gain_c;
          len_r  <= newlen;
        end
      end
      S_RB1: begin
        // walk source positions: a, b down to a+1, b+1 up to n-1, 0 up to a-1
        case (seg_r)
          2'd0: begin
            seg_r <= 2'd1;
            src_r <= b_r;
          end
          2'd1: begin
            if (src_r == a_r + CW'(1)) begin
              seg_r <= 2'd2;
              src_r <= b_r + CW'(1);
            end else begin
              src_r <= src_r - CW'(1);
            end
          end
          2'd2: begin
            if ({1'b0, src_r} == nn - NW'(1)) begin
              seg_r <= 2'd3;
              src_r <= '0;
            end else begin
              src_r <= src_r + CW'(1);
            end
          end
          default: src_r <= src_r + CW'(1);
        endcase
        cnt_r <= (cnt_r == nn) ? '0 : cnt_r + NW'(1);
      end
      S_RB2: cnt_r <= cnt_r + NW'(1);
      default: begin
      end
    endcase
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTH
  a_best_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> best_len_r <= $past(best_len_r))
    else $error("best length increased");

  a_accept_gain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.accepted |-> (out_r.gain != '0) && (out_r.status == ST_OK))
    else $error("accepted move without gain");

  a_rebuild_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RB1) || (state_r == S_RB2) |-> cnt_r <= nn)
    else $error("rebuild counter past tour end");
`endif

endmodule
